[rtl/uer_pkg.sv]
package uer_pkg;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_TRIGGER   = 2'd1,
    PH_WAIT_RISE = 2'd2,
    PH_MEASURE   = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ECHO_HIGH = 2'd1,
    ST_NO_ECHO   = 2'd2,
    ST_TOO_LONG  = 2'd3
  } status_t;

  localparam int unsigned ElapsedW = 16;
  localparam int unsigned DistW    = 10;
  localparam int unsigned CfgW     = 9;

  typedef struct packed {
    logic                 busy_res;
    logic [DistW-1:0]     distance_cm;
    status_t              status;
    logic                 done_res;
    logic                 trigger_level;
  } result_t;

endpackage

[rtl/ultrasonic_echo_ranger.sv]
// Channel  | Ports                           | Transaction
// ---------+---------------------------------+----------------------------------------
// input    | in_tvalid/in_tready/in_tdata    | one microsecond tick with echo sample
// result   | out_tvalid/out_tready/out_tdata | one result per input tick
// config   | cfg_wr_en/cfg_wr_data           | max_distance_cm write, clamped
//
// One tick per cycle while in_tready is high: the phase update and result are formed in the accept cycle
// and land in the output register, seen in the cycle after.
// in_tready drops only while a result is held and out_tready is low.
// rst_n (synchronous) returns to idle with no result pending; the timeout
// register reloads from the reset range.
module ultrasonic_echo_ranger
  import uer_pkg::*;
#(
  parameter int unsigned MAX_DISTANCE_CM     = 500,
  parameter int unsigned ROUNDTRIP_US_PER_CM = 57,
  parameter int unsigned TRIGGER_WIDTH_US    = 10,
  parameter int unsigned EXTRA_DELAY_US      = 5800
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,     // [0] start_request, [1] echo_level
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [15:0]     out_tdata,    // [0] trigger_level, [1] done_res,
                                        // [3:2] status, [13:4] distance_cm,
                                        // [14] busy_res
  input  logic            cfg_wr_en,
  input  logic [CfgW-1:0] cfg_wr_data
);

  localparam int unsigned CfgMax  = (1 << CfgW) - 1;
  localparam int unsigned SumMax  = CfgMax * ROUNDTRIP_US_PER_CM + EXTRA_DELAY_US;
  localparam int unsigned SumW    = $clog2(SumMax + 1);
  localparam int unsigned RstDist = (500 <= MAX_DISTANCE_CM) ? 500 : MAX_DISTANCE_CM;
  localparam int unsigned RstSum  = RstDist * ROUNDTRIP_US_PER_CM + EXTRA_DELAY_US;
  localparam int unsigned ElapsedMax = (1 << ElapsedW) - 1;
  localparam int unsigned RstTmo  = (RstSum > ElapsedMax) ? ElapsedMax : RstSum;
  localparam int unsigned SubW    = (ROUNDTRIP_US_PER_CM > 1) ?
                                    $clog2(ROUNDTRIP_US_PER_CM) : 1;
  localparam int unsigned MaxW    = $clog2(MAX_DISTANCE_CM + 1) > CfgW ?
                                    $clog2(MAX_DISTANCE_CM + 1) : CfgW;

  phase_t              phase_r, phase_nxt;
  logic [ElapsedW-1:0] elapsed_r, elapsed_nxt;
  logic [DistW-1:0]    cm_r, cm_nxt;
  logic [SubW-1:0]     sub_r, sub_nxt;
  logic [ElapsedW-1:0] timeout_r;
  logic                out_valid_r;
  result_t             out_data_r;
  result_t             res;

  logic                accept;
  logic                start, echo;
  logic [ElapsedW-1:0] elapsed_inc;
  logic [MaxW-1:0]     cfg_clamped;
  logic [SumW-1:0]     cfg_sum;
  logic [SubW-1:0]     sub_tick;
  logic [DistW-1:0]    cm_tick;
  logic                sub_wrap;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = !out_valid_r || out_tready;
  assign start     = in_tdata[0];
  assign echo      = in_tdata[1];

  assign cfg_clamped = (MaxW'(cfg_wr_data) <= MaxW'(MAX_DISTANCE_CM)) ?
                       MaxW'(cfg_wr_data) : MaxW'(MAX_DISTANCE_CM);
  assign cfg_sum     = SumW'(cfg_clamped) * SumW'(ROUNDTRIP_US_PER_CM)
                       + SumW'(EXTRA_DELAY_US);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= ElapsedW'(RstTmo);
    end else if (cfg_wr_en) begin
      timeout_r <= (cfg_sum > SumW'(ElapsedMax)) ? ElapsedW'(ElapsedMax)
                                                  : ElapsedW'(cfg_sum);
    end
  end

  assign elapsed_inc = (elapsed_r == ElapsedW'(ElapsedMax)) ? elapsed_r
                                                            : elapsed_r + 1'b1;

  // echo tick counting, shared by the rise tick (from zero) and measure ticks
  always_comb begin
    logic [SubW-1:0]  sub_base;
    logic [DistW-1:0] cm_base;
    sub_base = (phase_r == PH_MEASURE) ? sub_r : '0;
    cm_base  = (phase_r == PH_MEASURE) ? cm_r : '0;
    sub_wrap = (sub_base == SubW'(ROUNDTRIP_US_PER_CM - 1));
    sub_tick = sub_wrap ? '0 : sub_base + 1'b1;
    cm_tick  = (sub_wrap && cm_base != '1) ? cm_base + 1'b1 : cm_base;
  end

  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    cm_nxt      = cm_r;
    sub_nxt     = sub_r;
    res         = '0;
    res.status  = ST_OK;
    unique case (phase_r)
      PH_IDLE: begin
        if (start) begin
          if (echo) begin
            res.done_res = 1'b1;
            res.status   = ST_ECHO_HIGH;
          end else begin
            res.trigger_level = 1'b1;
            cm_nxt            = '0;
            sub_nxt           = '0;
            if (TRIGGER_WIDTH_US <= 1) begin
              phase_nxt   = PH_WAIT_RISE;
              elapsed_nxt = '0;
            end else begin
              phase_nxt   = PH_TRIGGER;
              elapsed_nxt = ElapsedW'(1);
            end
          end
        end
      end
      PH_TRIGGER: begin
        res.trigger_level = 1'b1;
        elapsed_nxt       = elapsed_inc;
        if (elapsed_inc >= ElapsedW'(TRIGGER_WIDTH_US)) begin
          phase_nxt   = PH_WAIT_RISE;
          elapsed_nxt = '0;
        end
      end
      PH_WAIT_RISE: begin
        if (echo) begin
          phase_nxt   = PH_MEASURE;
          elapsed_nxt = ElapsedW'(1);
          cm_nxt      = cm_tick;
          sub_nxt     = sub_tick;
          if (ElapsedW'(1) >= timeout_r) begin
            phase_nxt    = PH_IDLE;
            res.done_res = 1'b1;
            res.status   = ST_TOO_LONG;
          end
        end else begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= timeout_r) begin
            phase_nxt    = PH_IDLE;
            res.done_res = 1'b1;
            res.status   = ST_NO_ECHO;
          end
        end
      end
      PH_MEASURE: begin
        if (echo) begin
          elapsed_nxt = elapsed_inc;
          cm_nxt      = cm_tick;
          sub_nxt     = sub_tick;
          if (elapsed_inc >= timeout_r) begin
            phase_nxt    = PH_IDLE;
            res.done_res = 1'b1;
            res.status   = ST_TOO_LONG;
          end
        end else begin
          phase_nxt       = PH_IDLE;
          res.done_res    = 1'b1;
          res.status      = ST_OK;
          res.distance_cm = cm_r;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
    res.busy_res = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      elapsed_r <= '0;
      cm_r      <= '0;
      sub_r     <= '0;
    end else if (accept) begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      cm_r      <= cm_nxt;
      sub_r     <= sub_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};

endmodule

[rtl/uer_checker.sv]
module uer_checker
  import uer_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");

  // every accepted tick yields a result in the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("missing result after accepted tick");

  // status and distance are zero unless a measurement ends
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[1] |-> out_tdata[13:2] == 12'd0)
    else $error("status or distance set without done");

  // a failed measurement reports no distance
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[3:2] != ST_OK |-> out_tdata[13:4] == 10'd0)
    else $error("distance reported on failure");

  // trigger is never driven in the tick a measurement ends, and only while busy
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> !out_tdata[1] && out_tdata[14])
    else $error("trigger with done or without busy");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
